>>> rtl/gzip_header_parser_unit_macros.svh
// ----------------------------------------------------------------------------
// gzip header parser assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef GZIP_HEADER_PARSER_UNIT_MACROS_SVH
`define GZIP_HEADER_PARSER_UNIT_MACROS_SVH

// same-cycle implication, masked during reset
`define GHP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gzip header parser check failed");

// next-cycle implication, masked during reset
`define GHP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gzip header parser check failed");

// next-cycle implication that also holds across reset
`define GHP_ASSERT_RESET(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("gzip header parser check failed");

`endif

>>> rtl/ghp_pkg.sv
// ----------------------------------------------------------------------------
// ghp_pkg
// Types, codes and helpers for the gzip member header parser.
// ----------------------------------------------------------------------------
package ghp_pkg;

    localparam int unsigned LENGTH_BITS_DEF = 20;
    localparam int unsigned HDR_LEN_W       = 20;

    localparam logic [7:0] ID1_BYTE      = 8'h1f;
    localparam logic [7:0] ID2_BYTE      = 8'h8b;
    localparam logic [7:0] METHOD_MAX    = 8'd8;
    localparam logic [2:0] RSVD_FLG_MASK = 3'h7;

    // parse phases, also reported as field kind
    localparam logic [3:0] PH_ID1     = 4'd0;
    localparam logic [3:0] PH_ID2     = 4'd1;
    localparam logic [3:0] PH_METHOD  = 4'd2;
    localparam logic [3:0] PH_FLAGS   = 4'd3;
    localparam logic [3:0] PH_MTIME   = 4'd4;
    localparam logic [3:0] PH_XFL     = 4'd5;
    localparam logic [3:0] PH_OS      = 4'd6;
    localparam logic [3:0] PH_XLEN    = 4'd7;
    localparam logic [3:0] PH_EXTRA   = 4'd8;
    localparam logic [3:0] PH_NAME    = 4'd9;
    localparam logic [3:0] PH_COMMENT = 4'd10;
    localparam logic [3:0] PH_HCRC    = 4'd11;
    localparam logic [3:0] PH_PAYLOAD = 4'd12;
    localparam logic [3:0] PH_ERROR   = 4'd13;

    localparam logic [2:0] ST_PARSING = 3'd0;
    localparam logic [2:0] ST_END     = 3'd1;
    localparam logic [2:0] ST_ERROR   = 3'd2;
    localparam logic [2:0] ST_PAYLOAD = 3'd3;
    localparam logic [2:0] ST_IDLE    = 3'd4;

    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_ID1    = 3'd1;
    localparam logic [2:0] ERR_ID2    = 3'd2;
    localparam logic [2:0] ERR_METHOD = 3'd3;
    localparam logic [2:0] ERR_FLAGS  = 3'd4;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       start_of_stream;
    } t_in_word;

    typedef struct packed {
        logic [3:0]           field_kind;
        logic [2:0]           parse_status;
        logic [2:0]           error_code;
        logic [HDR_LEN_W-1:0] header_length;
        logic [31:0]          mod_time;
        logic [4:0]           header_flags;
        logic [7:0]           extra_flags;
        logic [7:0]           os_code;
        logic [3:0]           method_code;
    } t_out_word;

    // first optional field at or after 'from' that FLG asks for
    function automatic logic [3:0] next_optional(input logic [3:0] from,
                                                 input logic [4:0] flg);
        logic [3:0] ph;
        if (from <= PH_XLEN && flg[2]) begin
            ph = PH_XLEN;
        end else if (from <= PH_NAME && flg[3]) begin
            ph = PH_NAME;
        end else if (from <= PH_COMMENT && flg[4]) begin
            ph = PH_COMMENT;
        end else if (from <= PH_HCRC && flg[1]) begin
            ph = PH_HCRC;
        end else begin
            ph = PH_PAYLOAD;
        end
        return ph;
    endfunction

endpackage

>>> rtl/ghp_core.sv
// ----------------------------------------------------------------------------
// ghp_core
// Header parse state and per-byte next-state / result logic.
// ----------------------------------------------------------------------------
module ghp_core #(
    parameter int unsigned LENGTH_BITS = ghp_pkg::LENGTH_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  ghp_pkg::t_in_word   i_word,
    output ghp_pkg::t_out_word  o_word
);
    import ghp_pkg::*;

    localparam int unsigned EXT_W = (LENGTH_BITS > HDR_LEN_W) ? LENGTH_BITS : HDR_LEN_W;

    logic [3:0]             r_phase, n_phase, ph;
    logic [1:0]             r_bif, n_bif, bif;
    logic [4:0]             r_flags, n_flags, flg;
    logic [31:0]            r_mtime, n_mtime, mtm;
    logic [7:0]             r_xfl, n_xfl, xfl;
    logic [7:0]             r_os, n_os, osc;
    logic [3:0]             r_method, n_method, mth;
    logic [15:0]            r_rem, n_rem, rem;
    logic [LENGTH_BITS-1:0] r_len, n_len, len;
    logic [2:0]             r_err, n_err, err;
    logic [2:0]             status, err_out;
    logic [15:0]            rem_dec;
    logic [EXT_W-1:0]       len_ext;
    logic [7:0]             b;

    always_comb begin
        b = i_word.stream_byte;
        if (i_word.start_of_stream) begin
            ph  = PH_ID1;
            bif = '0;
            flg = '0;
            mtm = '0;
            xfl = '0;
            osc = '0;
            mth = '0;
            rem = '0;
            len = '0;
            err = ERR_NONE;
        end else begin
            ph  = (r_phase > PH_ERROR) ? PH_ERROR : r_phase;
            bif = r_bif;
            flg = r_flags;
            mtm = r_mtime;
            xfl = r_xfl;
            osc = r_os;
            mth = r_method;
            rem = r_rem;
            len = r_len;
            err = r_err;
        end

        n_phase  = ph;
        n_bif    = bif;
        n_flags  = flg;
        n_mtime  = mtm;
        n_xfl    = xfl;
        n_os     = osc;
        n_method = mth;
        n_rem    = rem;
        n_len    = len;
        n_err    = err;
        status   = ST_PARSING;
        err_out  = ERR_NONE;
        rem_dec  = (rem != '0) ? rem - 16'd1 : rem;

        if (ph != PH_PAYLOAD && ph != PH_ERROR && len != '1) begin
            n_len = len + LENGTH_BITS'(1);
        end

        unique case (ph)
            PH_ID1: begin
                if (b != ID1_BYTE) begin
                    n_err = ERR_ID1; n_phase = PH_ERROR; n_bif = '0; status = ST_ERROR;
                end else begin
                    n_phase = PH_ID2;
                end
            end
            PH_ID2: begin
                if (b != ID2_BYTE) begin
                    n_err = ERR_ID2; n_phase = PH_ERROR; n_bif = '0; status = ST_ERROR;
                end else begin
                    n_phase = PH_METHOD;
                end
            end
            PH_METHOD: begin
                if (b > METHOD_MAX) begin
                    n_err = ERR_METHOD; n_phase = PH_ERROR; n_bif = '0; status = ST_ERROR;
                end else begin
                    n_method = b[3:0];
                    n_phase  = PH_FLAGS;
                end
            end
            PH_FLAGS: begin
                if ((b[7:5] & RSVD_FLG_MASK) != '0) begin
                    n_err = ERR_FLAGS; n_phase = PH_ERROR; n_bif = '0; status = ST_ERROR;
                end else begin
                    n_flags = b[4:0];
                    n_phase = PH_MTIME;
                    n_bif   = '0;
                end
            end
            PH_MTIME: begin
                n_mtime[{bif, 3'b000} +: 8] = b;
                if (bif == 2'd3) begin
                    n_phase = PH_XFL;
                    n_bif   = '0;
                end else begin
                    n_bif = bif + 2'd1;
                end
            end
            PH_XFL: begin
                n_xfl   = b;
                n_phase = PH_OS;
            end
            PH_OS: begin
                n_os    = b;
                n_phase = next_optional(PH_XLEN, flg);
                n_bif   = '0;
                status  = (n_phase == PH_PAYLOAD) ? ST_END : ST_PARSING;
            end
            PH_XLEN: begin
                if (bif == '0) begin
                    n_rem = {8'h00, b};
                    n_bif = 2'd1;
                end else begin
                    n_rem = rem | {b, 8'h00};
                    n_bif = '0;
                    if (n_rem == '0) begin
                        n_phase = next_optional(PH_NAME, flg);
                        status  = (n_phase == PH_PAYLOAD) ? ST_END : ST_PARSING;
                    end else begin
                        n_phase = PH_EXTRA;
                    end
                end
            end
            PH_EXTRA: begin
                n_rem = rem_dec;
                if (rem_dec == '0) begin
                    n_phase = next_optional(PH_NAME, flg);
                    n_bif   = '0;
                    status  = (n_phase == PH_PAYLOAD) ? ST_END : ST_PARSING;
                end
            end
            PH_NAME: begin
                if (b == 8'h00) begin
                    n_phase = next_optional(PH_COMMENT, flg);
                    n_bif   = '0;
                    status  = (n_phase == PH_PAYLOAD) ? ST_END : ST_PARSING;
                end
            end
            PH_COMMENT: begin
                if (b == 8'h00) begin
                    n_phase = next_optional(PH_HCRC, flg);
                    n_bif   = '0;
                    status  = (n_phase == PH_PAYLOAD) ? ST_END : ST_PARSING;
                end
            end
            PH_HCRC: begin
                if (bif == '0) begin
                    n_bif = 2'd1;
                end else begin
                    n_phase = PH_PAYLOAD;
                    n_bif   = '0;
                    status  = ST_END;
                end
            end
            PH_PAYLOAD: begin
                status = ST_PAYLOAD;
            end
            default: begin
                status  = ST_IDLE;
                err_out = err;
            end
        endcase

        if (status == ST_ERROR) begin
            err_out = n_err;
        end

        len_ext = EXT_W'(n_len);

        o_word.field_kind    = ph;
        o_word.parse_status  = status;
        o_word.error_code    = err_out;
        o_word.header_length = len_ext[HDR_LEN_W-1:0];
        o_word.mod_time      = n_mtime;
        o_word.header_flags  = n_flags;
        o_word.extra_flags   = n_xfl;
        o_word.os_code       = n_os;
        o_word.method_code   = n_method;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_ID1;
            r_bif    <= '0;
            r_flags  <= '0;
            r_mtime  <= '0;
            r_xfl    <= '0;
            r_os     <= '0;
            r_method <= '0;
            r_rem    <= '0;
            r_len    <= '0;
            r_err    <= ERR_NONE;
        end else if (i_en) begin
            r_phase  <= n_phase;
            r_bif    <= n_bif;
            r_flags  <= n_flags;
            r_mtime  <= n_mtime;
            r_xfl    <= n_xfl;
            r_os     <= n_os;
            r_method <= n_method;
            r_rem    <= n_rem;
            r_len    <= n_len;
            r_err    <= n_err;
        end
    end

endmodule

>>> rtl/ghp_out_stage.sv
// ----------------------------------------------------------------------------
// ghp_out_stage
// Result register with a skid entry; decouples output stall from input.
// ----------------------------------------------------------------------------
module ghp_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ghp_pkg::t_out_word i_word,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_stall,
    output ghp_pkg::t_out_word o_word
);
    import ghp_pkg::*;

    logic      r_main_valid, r_skid_valid;
    t_out_word r_main, r_skid;
    logic      pop;

    assign pop     = r_main_valid && !i_stall;
    assign o_valid = r_main_valid;
    assign o_word  = r_main;
    assign o_full  = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            if (!r_main_valid) begin
                r_main_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_main <= r_skid_valid ? r_skid : i_word;
        end else if (i_push) begin
            if (!r_main_valid) begin
                r_main <= i_word;
            end else begin
                r_skid <= i_word;
            end
        end
    end

endmodule

>>> rtl/gzip_header_parser_unit.sv
// ----------------------------------------------------------------------------
// gzip_header_parser_unit
// Byte-serial gzip member header parser (field kind and status per byte).
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one stream byte per word, with
// a start flag that restarts parsing on that byte as ID1.
// Output channel: o_out_valid / i_out_stall carry one result word per input
// word: field kind, parse status, error code, header length so far and the
// captured MTIME, FLG, XFL, OS and method values.
// A result is registered in the result register, or on a stall in the skid entry.
// Throughput: one byte per cycle while o_in_stall is low; each step is one pass
// through the parse logic into the result register or the skid entry.
// Reset: all parse state and captured fields clear; the first byte is parsed
// as ID1 with or without a start flag. No result is pending after reset.
// Output stall: one result waits in the result register and one more in a
// skid entry; o_in_stall rises only when the skid entry is occupied.
// ----------------------------------------------------------------------------
module gzip_header_parser_unit #(
    parameter int unsigned LENGTH_BITS = ghp_pkg::LENGTH_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ghp_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ghp_pkg::t_out_word o_out_word
);
    import ghp_pkg::*;

    logic      accept;
    logic      full;
    t_out_word result;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    ghp_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_word  (i_in_word),
        .o_word  (result)
    );

    ghp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_word  (result),
        .o_full  (full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_word  (o_out_word)
    );

endmodule

>>> rtl/ghp_checker.sv
// ----------------------------------------------------------------------------
// ghp_checker
// Port-level checks for the gzip header parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "gzip_header_parser_unit_macros.svh"

module ghp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input ghp_pkg::t_in_word  i_in_word,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input ghp_pkg::t_out_word o_out_word
);
    import ghp_pkg::*;

    `GHP_ASSERT_RESET(a_rst_empty, !i_rst_n, !o_out_valid && !o_in_stall)
    `GHP_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_word))
    `GHP_ASSERT_SAME(a_stall_backed, o_in_stall, o_out_valid)
    `GHP_ASSERT_SAME(a_err_code, o_out_valid && o_out_word.parse_status == ST_ERROR, o_out_word.error_code != ERR_NONE && o_out_word.field_kind <= PH_FLAGS)
    `GHP_ASSERT_SAME(a_payload_clean, o_out_valid && o_out_word.parse_status == ST_PAYLOAD, o_out_word.error_code == ERR_NONE && o_out_word.field_kind == PH_PAYLOAD)

endmodule

bind gzip_header_parser_unit ghp_checker u_ghp_checker (.*);
